// File: rtl/tcps_pkg.sv
// shared types, constants and helpers for the two-colour pixel share scorer
// no dependencies; imported by every module of the block
package tcps_pkg;

  localparam int CHAN_W  = 8;
  localparam int RGB_W   = 24;
  localparam int DIST_W  = 18;
  localparam int LIM_W   = 18;
  localparam int CNT_W   = 23;
  localparam int SCORE_W = 15;
  localparam int SUM_W   = 32;   // capped score numerator, at most 300 * n
  localparam int DIVR_W  = 25;   // divisor 3 * n
  localparam int DIV_STEPS = 15; // quotient bits, score never exceeds 25600
  localparam int STEP_W  = 4;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam int unsigned MAX_PIXELS = 4194304;
  localparam int unsigned FIELD_MAX  = 8388607;
  localparam logic [CNT_W-1:0] CNT_CAP =
    CNT_W'((MAX_PIXELS > FIELD_MAX) ? FIELD_MAX : MAX_PIXELS);

  localparam int Q_DEPTH = 4;

  // score weights
  localparam logic [SUM_W-1:0] W_LOOSE    = SUM_W'(400);
  localparam logic [SUM_W-1:0] W_STRICT   = SUM_W'(300);
  localparam logic [SUM_W-1:0] CAP_LOOSE  = SUM_W'(120);
  localparam logic [SUM_W-1:0] CAP_STRICT = SUM_W'(30);

  typedef enum logic [2:0] {
    REG_FIRST_RGB   = 3'd0,
    REG_SECOND_RGB  = 3'd1,
    REG_STRICT_LIM  = 3'd2,
    REG_FIRST_LIM   = 3'd3,
    REG_SECOND_LIM  = 3'd4
  } reg_idx_t;

  localparam logic [RGB_W-1:0] RST_FIRST_RGB  = 24'h2866D7;
  localparam logic [RGB_W-1:0] RST_SECOND_RGB = 24'hE38A17;
  localparam logic [LIM_W-1:0] RST_STRICT_LIM = LIM_W'(1950);
  localparam logic [LIM_W-1:0] RST_FIRST_LIM  = LIM_W'(29670);
  localparam logic [LIM_W-1:0] RST_SECOND_LIM = LIM_W'(23896);

  typedef struct packed {
    logic [RGB_W-1:0] first_rgb;
    logic [RGB_W-1:0] second_rgb;
    logic [LIM_W-1:0] strict_lim;
    logic [LIM_W-1:0] first_lim;
    logic [LIM_W-1:0] second_lim;
  } cfg_t;

  // classified pixel travelling from front to back
  typedef struct packed {
    logic last;
    logic first_loose;
    logic first_strict;
    logic second_loose;
    logic second_strict;
  } cls_t;

  typedef struct packed {
    logic [CNT_W-1:0]   first_count;
    logic [CNT_W-1:0]   second_count;
    logic [CNT_W-1:0]   first_strict_count;
    logic [CNT_W-1:0]   second_strict_count;
    logic [CNT_W-1:0]   frame_pixels;
    logic [SCORE_W-1:0] score_q8;
  } result_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] c,
                                                input logic en);
    sat_bump = (en && (c < CNT_CAP)) ? (c + 1'b1) : c;
  endfunction

  function automatic logic [SUM_W-1:0] min_of(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
    min_of = (a < b) ? a : b;
  endfunction

endpackage

// File: rtl/tcps_front.sv
// front end: takes pixel requests, measures squared distance to both targets
// and classifies each pixel; depends on tcps_pkg
module tcps_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tcps_pkg::CHAN_W-1:0]   in_red,
  input  logic [tcps_pkg::CHAN_W-1:0]   in_green,
  input  logic [tcps_pkg::CHAN_W-1:0]   in_blue,
  input  logic                          in_last_pixel,
  input  tcps_pkg::cfg_t                cfg,
  output logic                          push,
  output tcps_pkg::cls_t                push_cls,
  input  logic                          q_full
);
  import tcps_pkg::*;

  logic              move;
  logic              s1_v_r;
  logic              s1_last_r;
  logic [CHAN_W-1:0] a_r_r, a_g_r, a_b_r;
  logic [CHAN_W-1:0] b_r_r, b_g_r, b_b_r;
  logic              s2_v_r;
  logic              s2_last_r;
  logic [DIST_W-1:0] dist1_r, dist2_r;
  logic [15:0]       sq_ar, sq_ag, sq_ab, sq_br, sq_bg, sq_bb;
  logic [DIST_W-1:0] dist1_nxt, dist2_nxt;
  logic              pick_first;

  // whole pipe halts when the last stage cannot hand over
  assign move     = !(s2_v_r && q_full);
  assign in_stall = !move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (move) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      s1_last_r <= in_last_pixel;
      a_r_r     <= abs_diff(cfg.first_rgb[23:16], in_red);
      a_g_r     <= abs_diff(cfg.first_rgb[15:8], in_green);
      a_b_r     <= abs_diff(cfg.first_rgb[7:0], in_blue);
      b_r_r     <= abs_diff(cfg.second_rgb[23:16], in_red);
      b_g_r     <= abs_diff(cfg.second_rgb[15:8], in_green);
      b_b_r     <= abs_diff(cfg.second_rgb[7:0], in_blue);
      s2_last_r <= s1_last_r;
      dist1_r   <= dist1_nxt;
      dist2_r   <= dist2_nxt;
    end
  end

  always_comb begin
    sq_ar = a_r_r * a_r_r;
    sq_ag = a_g_r * a_g_r;
    sq_ab = a_b_r * a_b_r;
    sq_br = b_r_r * b_r_r;
    sq_bg = b_g_r * b_g_r;
    sq_bb = b_b_r * b_b_r;
    dist1_nxt = DIST_W'(sq_ar) + DIST_W'(sq_ag) + DIST_W'(sq_ab);
    dist2_nxt = DIST_W'(sq_br) + DIST_W'(sq_bg) + DIST_W'(sq_bb);
  end

  // a tie goes to the second colour
  assign pick_first = dist1_r < dist2_r;
  assign push       = s2_v_r && !q_full;

  always_comb begin
    push_cls.last          = s2_last_r;
    push_cls.first_loose   = pick_first && (dist1_r <= cfg.first_lim);
    push_cls.first_strict  = pick_first && (dist1_r <= cfg.strict_lim);
    push_cls.second_loose  = !pick_first && (dist2_r <= cfg.second_lim);
    push_cls.second_strict = !pick_first && (dist2_r <= cfg.strict_lim);
  end

endmodule

// File: rtl/tcps_queue.sv
// short fifo of classified pixels between front and back end
// depends on tcps_pkg
module tcps_queue #(
  parameter int DEPTH = tcps_pkg::Q_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcps_pkg::cls_t push_cls,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output tcps_pkg::cls_t head_cls
);
  import tcps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  cls_t              mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0] count_r;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : (p + 1'b1);
  endfunction

  assign full      = (count_r == CNT_QW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cls  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= next_ptr(wr_ptr_r);
      if (pop)  rd_ptr_r <= next_ptr(rd_ptr_r);
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cls;
  end

endmodule

// File: rtl/tcps_back.sv
// back end: saturating frame counters and the per-frame score unit
// (capped sum, then one quotient bit per cycle); depends on tcps_pkg
module tcps_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  tcps_pkg::cls_t    q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output tcps_pkg::result_t res
);
  import tcps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TERM = 5'b00010,
    S_SUM  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } score_state_t;

  score_state_t       state_r;
  logic [CNT_W-1:0]   c1_r, c2_r, s1_r, s2_r, n_r;
  logic [CNT_W-1:0]   c1_nxt, c2_nxt, s1_nxt, s2_nxt, n_nxt;
  logic [CNT_W-1:0]   f_c1_r, f_c2_r, f_s1_r, f_s2_r, f_n_r;
  logic [SUM_W-1:0]   p1_r, p2_r, p3_r, p4_r, cap_l_r, cap_s_r;
  logic [DIVR_W-1:0]  div_r;
  logic [DIVR_W-1:0]  rem_r;
  logic [DIV_STEPS-1:0] dsh_r;
  logic [SCORE_W-1:0] quo_r;
  logic [STEP_W-1:0]  step_r;
  logic [SUM_W-1:0]   num;
  logic [DIVR_W:0]    trial;
  logic               ge;
  logic               busy;
  logic               out_free;
  logic               out_valid_r;
  result_t            res_r;

  assign busy     = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  // a frame end waits until the score unit has let go of the last frame
  assign pop      = q_not_empty && !(q_head.last && busy);

  always_comb begin
    c1_nxt = sat_bump(c1_r, q_head.first_loose);
    c2_nxt = sat_bump(c2_r, q_head.second_loose);
    s1_nxt = sat_bump(s1_r, q_head.first_strict);
    s2_nxt = sat_bump(s2_r, q_head.second_strict);
    n_nxt  = sat_bump(n_r, 1'b1);
  end

  always_comb begin
    num = min_of(p1_r, cap_l_r) + min_of(p2_r, cap_l_r)
        + min_of(p3_r, cap_s_r) + min_of(p4_r, cap_s_r);
    trial = {rem_r, dsh_r[DIV_STEPS-1]};
    ge    = (trial >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      s1_r <= '0;
      s2_r <= '0;
      n_r  <= '0;
    end else if (pop) begin
      if (q_head.last) begin
        c1_r <= '0;
        c2_r <= '0;
        s1_r <= '0;
        s2_r <= '0;
        n_r  <= '0;
      end else begin
        c1_r <= c1_nxt;
        c2_r <= c2_nxt;
        s1_r <= s1_nxt;
        s2_r <= s2_nxt;
        n_r  <= n_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (pop && q_head.last) state_r <= S_TERM;
        S_TERM: state_r <= S_SUM;
        S_SUM:  state_r <= S_DIV;
        S_DIV:  if (step_r == STEP_W'(DIV_STEPS - 1)) state_r <= S_DONE;
        S_DONE: if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_head.last) begin
      f_c1_r <= c1_nxt;
      f_c2_r <= c2_nxt;
      f_s1_r <= s1_nxt;
      f_s2_r <= s2_nxt;
      f_n_r  <= n_nxt;
    end
    if (state_r == S_TERM) begin
      p1_r    <= SUM_W'(f_c1_r) * W_LOOSE;
      p2_r    <= SUM_W'(f_c2_r) * W_LOOSE;
      p3_r    <= SUM_W'(f_s1_r) * W_STRICT;
      p4_r    <= SUM_W'(f_s2_r) * W_STRICT;
      cap_l_r <= SUM_W'(f_n_r) * CAP_LOOSE;
      cap_s_r <= SUM_W'(f_n_r) * CAP_STRICT;
      div_r   <= (DIVR_W'(f_n_r) << 1) + DIVR_W'(f_n_r);
    end
    // dividend is num * 256; its top bits already sit below the divisor
    if (state_r == S_SUM) begin
      rem_r  <= num[SUM_W-1:SUM_W-DIVR_W];
      dsh_r  <= {num[SUM_W-DIVR_W-1:0], 8'd0};
      step_r <= '0;
    end
    if (state_r == S_DIV) begin
      rem_r  <= ge ? DIVR_W'(trial - {1'b0, div_r}) : trial[DIVR_W-1:0];
      dsh_r  <= dsh_r << 1;
      quo_r  <= {quo_r[SCORE_W-2:0], ge};
      step_r <= step_r + 1'b1;
    end
    if ((state_r == S_DONE) && out_free) begin
      res_r.first_count         <= f_c1_r;
      res_r.second_count        <= f_c2_r;
      res_r.first_strict_count  <= f_s1_r;
      res_r.second_strict_count <= f_s2_r;
      res_r.frame_pixels        <= f_n_r;
      res_r.score_q8            <= quo_r;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

// File: rtl/two_color_pixel_share_scorer.sv
// top level of the two-colour pixel share scorer: register file, front end,
// queue and back end; depends on tcps_pkg, tcps_front, tcps_queue, tcps_back
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | request   | in_valid / in_stall  | red, green, blue, last_pixel
//  out     | result    | out_valid / out_stall| four counts, frame_pixels, score_q8
//  cfg     | apb write | psel/penable/pwrite  | five target and limit registers
//
// pixels are taken one per clock unless in_stall is high; the front end is two
// stages deep and hands each classified pixel to a queue; the back end counts one
// pixel per clock unless a frame end waits. once the last pixel leaves the queue,
// the score takes a product stage, a sum stage, 15 divider steps, an output load;
// a further frame end waits for the score unit, so frames under 19 pixels stall.
// reset is synchronous and clears counters, queue and valid flags at once.
// in_stall rises only when the queue is full and the front end holds a pixel.
module two_color_pixel_share_scorer #(
  parameter int QUEUE_DEPTH = tcps_pkg::Q_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tcps_pkg::CHAN_W-1:0]   in_red,
  input  logic [tcps_pkg::CHAN_W-1:0]   in_green,
  input  logic [tcps_pkg::CHAN_W-1:0]   in_blue,
  input  logic                          in_last_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcps_pkg::CNT_W-1:0]    out_first_count,
  output logic [tcps_pkg::CNT_W-1:0]    out_second_count,
  output logic [tcps_pkg::CNT_W-1:0]    out_first_strict_count,
  output logic [tcps_pkg::CNT_W-1:0]    out_second_strict_count,
  output logic [tcps_pkg::CNT_W-1:0]    out_frame_pixels,
  output logic [tcps_pkg::SCORE_W-1:0]  out_score_q8,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcps_pkg::ADDR_W-1:0]   paddr,
  input  logic [tcps_pkg::DATA_W-1:0]   pwdata,
  output logic [tcps_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import tcps_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     wr_en;
  logic     push, q_full, q_not_empty, pop;
  cls_t     push_cls, head_cls;
  result_t  res;

  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_rgb  <= RST_FIRST_RGB;
      cfg_r.second_rgb <= RST_SECOND_RGB;
      cfg_r.strict_lim <= RST_STRICT_LIM;
      cfg_r.first_lim  <= RST_FIRST_LIM;
      cfg_r.second_lim <= RST_SECOND_LIM;
    end else if (wr_en) begin
      // addresses past the last register are dropped
      case (reg_idx)
        REG_FIRST_RGB:  cfg_r.first_rgb  <= pwdata[RGB_W-1:0];
        REG_SECOND_RGB: cfg_r.second_rgb <= pwdata[RGB_W-1:0];
        REG_STRICT_LIM: cfg_r.strict_lim <= pwdata[LIM_W-1:0];
        REG_FIRST_LIM:  cfg_r.first_lim  <= pwdata[LIM_W-1:0];
        REG_SECOND_LIM: cfg_r.second_lim <= pwdata[LIM_W-1:0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FIRST_RGB:  prdata = DATA_W'(cfg_r.first_rgb);
      REG_SECOND_RGB: prdata = DATA_W'(cfg_r.second_rgb);
      REG_STRICT_LIM: prdata = DATA_W'(cfg_r.strict_lim);
      REG_FIRST_LIM:  prdata = DATA_W'(cfg_r.first_lim);
      REG_SECOND_LIM: prdata = DATA_W'(cfg_r.second_lim);
      default:        prdata = '0;
    endcase
  end

  tcps_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_last_pixel (in_last_pixel),
    .cfg           (cfg_r),
    .push          (push),
    .push_cls      (push_cls),
    .q_full        (q_full)
  );

  tcps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cls  (push_cls),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_cls  (head_cls)
  );

  tcps_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (head_cls),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res         (res)
  );

  assign out_first_count         = res.first_count;
  assign out_second_count        = res.second_count;
  assign out_first_strict_count  = res.first_strict_count;
  assign out_second_strict_count = res.second_strict_count;
  assign out_frame_pixels        = res.frame_pixels;
  assign out_score_q8            = res.score_q8;

endmodule

// File: rtl/tcps_checker.sv
// port-level checks on the result channel of the pixel share scorer,
// bound to the top level; depends on tcps_pkg
module tcps_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tcps_pkg::CNT_W-1:0]   out_first_count,
  input logic [tcps_pkg::CNT_W-1:0]   out_frame_pixels,
  input logic [tcps_pkg::SCORE_W-1:0] out_score_q8
);
  import tcps_pkg::*;

  // a stalled result stays up
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_score_q8) && $stable(out_frame_pixels))
    else $error("result changed while stalled");

  // score stays within 0 to 100 in q8
  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_score_q8 <= SCORE_W'(25600)))
    else $error("score out of range");

  // a frame is never empty and the first colour count never exceeds it
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_pixels != '0) && (out_first_count <= out_frame_pixels))
    else $error("frame counts inconsistent");

endmodule

bind two_color_pixel_share_scorer tcps_checker u_tcps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_first_count  (out_first_count),
  .out_frame_pixels (out_frame_pixels),
  .out_score_q8     (out_score_q8)
);

// File: test/two_color_pixel_share_scorer_tb.sv
// self-checking testbench for the two-colour pixel share scorer: drives pixel frames
// and apb register writes, predicts each frame's counts and score, checks every result
// depends on tcps_pkg and the two_color_pixel_share_scorer top level
`timescale 1ns / 1ps

module two_color_pixel_share_scorer_tb;
  import tcps_pkg::*;

  localparam int NUM_CFG_REGS  = 5;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int unsigned COUNT_LIMIT = (MAX_PIXELS > FIELD_MAX) ? FIELD_MAX : MAX_PIXELS;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CHAN_W-1:0]   in_red = '0;
  logic [CHAN_W-1:0]   in_green = '0;
  logic [CHAN_W-1:0]   in_blue = '0;
  logic                in_last_pixel = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CNT_W-1:0]    out_first_count;
  logic [CNT_W-1:0]    out_second_count;
  logic [CNT_W-1:0]    out_first_strict_count;
  logic [CNT_W-1:0]    out_second_strict_count;
  logic [CNT_W-1:0]    out_frame_pixels;
  logic [SCORE_W-1:0]  out_score_q8;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // predictor state: register shadow and frame tallies
  logic [31:0]         shadow_cfg [NUM_CFG_REGS];
  int unsigned         tally_first, tally_second, tally_first_strict, tally_second_strict;
  int unsigned         tally_pixels;
  result_t             frame_totals_q [$];

  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int unsigned         mismatch_count = 0;
  logic                recv_hold = 1'b0;
  event                hold_kick;

  two_color_pixel_share_scorer u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_red                  (in_red),
    .in_green                (in_green),
    .in_blue                 (in_blue),
    .in_last_pixel           (in_last_pixel),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_first_count         (out_first_count),
    .out_second_count        (out_second_count),
    .out_first_strict_count  (out_first_strict_count),
    .out_second_strict_count (out_second_strict_count),
    .out_frame_pixels        (out_frame_pixels),
    .out_score_q8            (out_score_q8),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned colour_dist(input logic [RGB_W-1:0] rgb,
                                              input logic [CHAN_W-1:0] r,
                                              input logic [CHAN_W-1:0] g,
                                              input logic [CHAN_W-1:0] b);
    int dr, dg, db;
    dr = int'(rgb[23:16]) - int'(r);
    dg = int'(rgb[15:8]) - int'(g);
    db = int'(rgb[7:0]) - int'(b);
    return dr * dr + dg * dg + db * db;
  endfunction

  function automatic int unsigned sat_inc(input int unsigned c);
    return (c < COUNT_LIMIT) ? c + 1 : c;
  endfunction

  function automatic longint unsigned capped(input longint unsigned v,
                                             input longint unsigned lim);
    return (v < lim) ? v : lim;
  endfunction

  task automatic account_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                               input logic [CHAN_W-1:0] b, input logic last);
    int unsigned d1, d2;
    longint unsigned n, num;
    result_t want;
    d1 = colour_dist(shadow_cfg[REG_FIRST_RGB][RGB_W-1:0], r, g, b);
    d2 = colour_dist(shadow_cfg[REG_SECOND_RGB][RGB_W-1:0], r, g, b);
    // a tie goes to the second colour
    if (d1 < d2) begin
      if (d1 <= shadow_cfg[REG_FIRST_LIM]) tally_first = sat_inc(tally_first);
      if (d1 <= shadow_cfg[REG_STRICT_LIM]) tally_first_strict = sat_inc(tally_first_strict);
    end else begin
      if (d2 <= shadow_cfg[REG_SECOND_LIM]) tally_second = sat_inc(tally_second);
      if (d2 <= shadow_cfg[REG_STRICT_LIM]) tally_second_strict = sat_inc(tally_second_strict);
    end
    tally_pixels = sat_inc(tally_pixels);
    if (last) begin
      n = tally_pixels;
      num = capped(400 * longint'(tally_first), 120 * n)
          + capped(400 * longint'(tally_second), 120 * n)
          + capped(300 * longint'(tally_first_strict), 30 * n)
          + capped(300 * longint'(tally_second_strict), 30 * n);
      want.first_count         = CNT_W'(tally_first);
      want.second_count        = CNT_W'(tally_second);
      want.first_strict_count  = CNT_W'(tally_first_strict);
      want.second_strict_count = CNT_W'(tally_second_strict);
      want.frame_pixels        = CNT_W'(tally_pixels);
      want.score_q8            = SCORE_W'((num * 256) / (3 * n));
      frame_totals_q.push_back(want);
      tally_first = 0;
      tally_second = 0;
      tally_first_strict = 0;
      tally_second_strict = 0;
      tally_pixels = 0;
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (frame_totals_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("result with no frame outstanding");
    end else begin
      want = frame_totals_q.pop_front();
      check_field("first_count", want.first_count, out_first_count);
      check_field("second_count", want.second_count, out_second_count);
      check_field("first_strict_count", want.first_strict_count, out_first_strict_count);
      check_field("second_strict_count", want.second_strict_count,
                  out_second_strict_count);
      check_field("frame_pixels", want.frame_pixels, out_frame_pixels);
      check_field("score_q8", want.score_q8, out_score_q8);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // long receiver hold-off, counted here
  initial forever begin
    @(hold_kick);
    recv_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    recv_hold <= 1'b0;
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_red        <= r;
    in_green      <= g;
    in_blue       <= b;
    in_last_pixel <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    account_pixel(r, g, b, last);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (frame_totals_q.size() != 0) @(posedge clk);
  endtask

  // let pixels that carry no result clear the pipeline too
  task automatic settle_block();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] cfg_mask(input int idx);
    return (idx == REG_FIRST_RGB || idx == REG_SECOND_RGB) ?
           (32'd1 << RGB_W) - 1 : (32'd1 << LIM_W) - 1;
  endfunction

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    int idx;
    idx = int'(addr >> 2);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr[1:0] == 2'b00 && idx < NUM_CFG_REGS) shadow_cfg[idx] = data & cfg_mask(idx);
    @(posedge clk);
  endtask

  task automatic write_cfg(input reg_idx_t idx, input logic [31:0] value);
    apb_write(ADDR_W'(int'(idx) * 4), value);
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [CHAN_W-1:0] jitter(input logic [CHAN_W-1:0] c, input int spread);
    int v;
    v = int'(c) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return CHAN_W'(v);
  endfunction

  // mostly pixels around one of the targets, some exact hits, some anywhere
  function automatic logic [RGB_W-1:0] pick_pixel();
    int unsigned kind;
    int spread;
    logic [RGB_W-1:0] base;
    kind = $urandom_range(99);
    spread = $urandom_range(1, 60);
    if (kind < 20) return RGB_W'($urandom);
    base = $urandom_range(1) ? shadow_cfg[REG_FIRST_RGB][RGB_W-1:0]
                             : shadow_cfg[REG_SECOND_RGB][RGB_W-1:0];
    if (kind < 30) return base;
    return {jitter(base[23:16], spread), jitter(base[15:8], spread),
            jitter(base[7:0], spread)};
  endfunction

  function automatic logic [31:0] pick_target();
    case ($urandom_range(4))
      0: return 32'h000000;
      1: return 32'hFFFFFF;
      2: return 32'(RST_FIRST_RGB);
      3: return 32'(RST_SECOND_RGB);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(6))
      0: return 32'd0;
      1: return 32'h3FFFF;
      2: return 32'd195075;
      3: return $urandom_range(195075);
      4: return $urandom;
      default: return $urandom_range(500, 40000);
    endcase
  endfunction

  task automatic randomise_config();
    write_cfg(REG_FIRST_RGB, pick_target());
    write_cfg(REG_SECOND_RGB, pick_target());
    write_cfg(REG_STRICT_LIM, pick_limit());
    write_cfg(REG_FIRST_LIM, pick_limit());
    write_cfg(REG_SECOND_LIM, pick_limit());
  endtask

  task automatic send_random_frame(input int unsigned len);
    logic [RGB_W-1:0] px;
    for (int unsigned i = 0; i < len; i++) begin
      px = pick_pixel();
      send_pixel(px[23:16], px[15:8], px[7:0], i == len - 1);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_default_colours();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    send_pixel(8'd40, 8'd102, 8'd215, 1'b0);
    send_pixel(8'd227, 8'd138, 8'd23, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
    // single-pixel frame
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
  endtask

  task automatic test_score_extremes();
    // full marks: both shares and both strict shares above their caps
    send_pixel(8'd40, 8'd102, 8'd215, 1'b0);
    send_pixel(8'd40, 8'd102, 8'd215, 1'b0);
    send_pixel(8'd227, 8'd138, 8'd23, 1'b0);
    send_pixel(8'd227, 8'd138, 8'd23, 1'b1);
    // nothing matches: zero score
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
  endtask

  task automatic test_ties_and_limits();
    settle_block();
    write_cfg(REG_FIRST_RGB, 32'h000000);
    write_cfg(REG_SECOND_RGB, 32'h020000);
    write_cfg(REG_STRICT_LIM, 32'd0);
    write_cfg(REG_FIRST_LIM, 32'd1);
    write_cfg(REG_SECOND_LIM, 32'd1);
    // writes past the last register must leave everything alone
    apb_write(ADDR_W'(NUM_CFG_REGS * 4), 32'hFFFF_FFFF);
    apb_write(ADDR_W'(7 * 4), 32'h0000_0000);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0);   // equidistant, second colour wins
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd2, 8'd0, 8'd0, 1'b1);
    settle_block();
    // opposite corners, limits wide open so every pixel counts
    write_cfg(REG_SECOND_RGB, 32'hFFFFFF);
    write_cfg(REG_STRICT_LIM, 32'hFFFF_FFFF);
    write_cfg(REG_FIRST_LIM, 32'd195075);
    write_cfg(REG_SECOND_LIM, 32'h3FFFF);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd127, 8'd127, 8'd127, 1'b1);
  endtask

  task automatic test_backpressure();
    logic [RGB_W-1:0] px;
    settle_block();
    randomise_config();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> hold_kick;
    for (int f = 0; f < 12; f++) begin
      for (int i = 0; i < 8; i++) begin
        px = pick_pixel();
        send_pixel(px[23:16], px[15:8], px[7:0], i == 7);
      end
    end
    // sender waits here until every frame has been reported
    wait_results();
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned pixel_budget);
    int unsigned sent;
    int unsigned len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int s = 0; s < 3; s++) begin
      settle_block();
      randomise_config();
      sent = 0;
      while (sent < pixel_budget / 3) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        send_random_frame(len);
        sent += len;
      end
    end
  endtask

  initial begin
    shadow_cfg[REG_FIRST_RGB]  = 32'(RST_FIRST_RGB);
    shadow_cfg[REG_SECOND_RGB] = 32'(RST_SECOND_RGB);
    shadow_cfg[REG_STRICT_LIM] = 32'(RST_STRICT_LIM);
    shadow_cfg[REG_FIRST_LIM]  = 32'(RST_FIRST_LIM);
    shadow_cfg[REG_SECOND_LIM] = 32'(RST_SECOND_LIM);
    tally_first = 0;
    tally_second = 0;
    tally_first_strict = 0;
    tally_second_strict = 0;
    tally_pixels = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_colours();
    test_score_extremes();
    test_ties_and_limits();
    test_backpressure();
    test_random_traffic(6, 58, 500);
    test_random_traffic(58, 6, 500);
    test_random_traffic(0, 0, 500);

    in_valid <= 1'b0;
    repeat (20000) if (frame_totals_q.size() != 0) @(posedge clk);
    mismatch_count += frame_totals_q.size();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: two_color_pixel_share_scorer.f
rtl/tcps_pkg.sv
rtl/tcps_front.sv
rtl/tcps_queue.sv
rtl/tcps_back.sv
rtl/two_color_pixel_share_scorer.sv
rtl/tcps_checker.sv
test/two_color_pixel_share_scorer_tb.sv
